/* hw/rtl/kspf_pkg.sv */
// Shared types, constants and the key translation table for the keypad scanner.
package kspf_pkg;

  localparam int unsigned ROWS  = 4;
  localparam int unsigned COLS  = 4;
  localparam int unsigned KEYS  = ROWS * COLS;
  localparam int unsigned ROW_W = 2;
  localparam int unsigned COL_W = 2;
  localparam int unsigned CODE_W = 4;

  // Command queue between front and back.
  localparam int unsigned CMDQ_DEPTH = 2;
  localparam int unsigned CMDQ_PTR_W = 1;
  localparam int unsigned CMDQ_CNT_W = 2;

  localparam logic OP_SCAN = 1'b0;
  localparam logic OP_GET  = 1'b1;

  // Letter key codes.
  localparam logic [CODE_W-1:0] KEY_A = 4'hA;
  localparam logic [CODE_W-1:0] KEY_B = 4'hB;
  localparam logic [CODE_W-1:0] KEY_C = 4'hC;
  localparam logic [CODE_W-1:0] KEY_D = 4'hD;
  localparam logic [CODE_W-1:0] KEY_E = 4'hE;
  localparam logic [CODE_W-1:0] KEY_F = 4'hF;

  typedef struct packed {
    logic              is_get;
    logic [ROWS-1:0]   new_mask;  // rows with a fresh press in this column
    logic [COL_W-1:0]  col;       // column that was sampled
    logic [COLS-1:0]   drive_n;   // column drive to report with the result
  } cmd_t;

  // Keypad legend, row r / column c.
  function automatic logic [CODE_W-1:0] key_lookup(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
    logic [CODE_W-1:0] code;
    case ({row, col})
      4'h0: code = 4'h1;
      4'h1: code = 4'h2;
      4'h2: code = 4'h3;
      4'h3: code = KEY_A;
      4'h4: code = 4'h4;
      4'h5: code = 4'h5;
      4'h6: code = 4'h6;
      4'h7: code = KEY_B;
      4'h8: code = 4'h7;
      4'h9: code = 4'h8;
      4'hA: code = 4'h9;
      4'hB: code = KEY_C;
      4'hC: code = 4'h0;
      4'hD: code = KEY_F;
      4'hE: code = KEY_E;
      default: code = KEY_D;
    endcase
    return code;
  endfunction

endpackage

/* hw/rtl/kspf_front.sv */
// Front end: takes input words, tracks the pressed map and column, emits commands.
module kspf_front import kspf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [3:0]  in_row_levels_n,
  output logic        cmd_valid,
  input  logic        cmd_ready,
  output cmd_t        cmd
);

  logic [KEYS-1:0]  pressed_map_r, pressed_map_nxt;
  logic [COL_W-1:0] scan_col_r, scan_col_nxt;
  logic [ROWS-1:0]  new_mask;
  logic [KEYS-1:0]  map_upd;
  logic             accept;

  assign in_ready  = cmd_ready;
  assign cmd_valid = in_valid;
  assign accept    = in_valid && cmd_ready;

  always_comb begin
    logic [3:0] idx;
    map_upd  = pressed_map_r;
    new_mask = '0;
    for (int r = 0; r < ROWS; r++) begin
      idx = {ROW_W'(r), scan_col_r};
      new_mask[r] = !in_row_levels_n[r] && !pressed_map_r[idx];
      map_upd[idx] = !in_row_levels_n[r];
    end
  end

  always_comb begin
    pressed_map_nxt = pressed_map_r;
    scan_col_nxt    = scan_col_r;
    if (accept && in_operation == OP_SCAN) begin
      pressed_map_nxt = map_upd;
      scan_col_nxt    = scan_col_r + COL_W'(1);
    end
  end

  always_comb begin
    cmd.is_get   = (in_operation == OP_GET);
    cmd.new_mask = cmd.is_get ? '0 : new_mask;
    cmd.col      = scan_col_r;
    cmd.drive_n  = ~(COLS'(1) << (cmd.is_get ? scan_col_r : scan_col_r + COL_W'(1)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pressed_map_r <= '0;
      scan_col_r    <= '0;
    end else begin
      pressed_map_r <= pressed_map_nxt;
      scan_col_r    <= scan_col_nxt;
    end
  end

endmodule

/* hw/rtl/kspf_cmd_queue.sv */
// Two-entry command queue between front and back.
module kspf_cmd_queue import kspf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  cmd_t                  entry_r [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CMDQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CMDQ_CNT_W-1:0] count_r, count_nxt;
  logic                  do_push, do_pop;

  assign push_ready = (count_r != CMDQ_CNT_W'(CMDQ_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + CMDQ_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + CMDQ_PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + CMDQ_CNT_W'(do_push) - CMDQ_CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

/* hw/rtl/kspf_back.sv */
// Back end: key code FIFO, one push per cycle unless the output register holds, pops, and the result register.
module kspf_back import kspf_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  cmd_t        cmd,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_column_drive_n,
  output logic        out_key_valid,
  output logic [3:0]  out_key_code,
  output logic        out_press_dropped
);

  localparam int unsigned PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

  logic [CODE_W-1:0] key_mem [FIFO_DEPTH];
  logic [CODE_W-1:0] rd_data_r;

  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, wr_ptr_inc;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt, rd_ptr_inc;

  logic            active_r, active_nxt;
  logic [ROWS-1:0] work_mask_r, work_mask_nxt;
  logic            drop_acc_r, drop_acc_nxt;

  logic            out_valid_r, out_valid_nxt;
  logic [COLS-1:0] out_drive_r, out_drive_nxt;
  logic            out_kv_r, out_kv_nxt;
  logic            out_drop_r, out_drop_nxt;

  logic [ROWS-1:0]  mask_cur, low_bit, rest;
  logic [ROW_W-1:0] low_row;
  logic             has_press, drop_cur;
  logic             full, empty, load_ok, last_step, step;
  logic             push_en, drop_now, pop_en;

  assign wr_ptr_inc = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
  assign rd_ptr_inc = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
  assign full  = (wr_ptr_inc == rd_ptr_r);
  assign empty = (wr_ptr_r == rd_ptr_r);

  assign mask_cur  = active_r ? work_mask_r : cmd.new_mask;
  assign drop_cur  = active_r && drop_acc_r;
  assign has_press = |mask_cur;

  // lowest pending row goes first
  always_comb begin
    if (mask_cur[0]) begin
      low_row = 2'd0;
    end else if (mask_cur[1]) begin
      low_row = 2'd1;
    end else if (mask_cur[2]) begin
      low_row = 2'd2;
    end else begin
      low_row = 2'd3;
    end
  end

  assign low_bit = has_press ? (ROWS'(1) << low_row) : '0;
  assign rest    = mask_cur & ~low_bit;

  assign load_ok   = !out_valid_r || out_ready;
  assign last_step = cmd.is_get || (rest == '0);
  assign step      = cmd_valid && (!last_step || load_ok);
  assign cmd_ready = step && last_step;

  assign push_en  = step && !cmd.is_get && has_press && !full;
  assign drop_now = step && !cmd.is_get && has_press && full;
  assign pop_en   = step && cmd.is_get && !empty;

  always_comb begin
    wr_ptr_nxt    = push_en ? wr_ptr_inc : wr_ptr_r;
    rd_ptr_nxt    = pop_en  ? rd_ptr_inc : rd_ptr_r;
    active_nxt    = active_r;
    work_mask_nxt = work_mask_r;
    drop_acc_nxt  = drop_acc_r;
    if (step) begin
      active_nxt    = !last_step;
      work_mask_nxt = rest;
      drop_acc_nxt  = drop_cur || drop_now;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_drive_nxt = out_drive_r;
    out_kv_nxt    = out_kv_r;
    out_drop_nxt  = out_drop_r;
    if (cmd_ready) begin
      out_valid_nxt = 1'b1;
      out_drive_nxt = cmd.drive_n;
      out_kv_nxt    = pop_en;
      out_drop_nxt  = !cmd.is_get && (drop_cur || drop_now);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      active_r    <= 1'b0;
      drop_acc_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      wr_ptr_r    <= wr_ptr_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      active_r    <= active_nxt;
      drop_acc_r  <= drop_acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_mask_r <= work_mask_nxt;
    out_drive_r <= out_drive_nxt;
    out_kv_r    <= out_kv_nxt;
    out_drop_r  <= out_drop_nxt;
  end

  // key store: one write, one registered read
  always_ff @(posedge clk) begin
    if (push_en) begin
      key_mem[wr_ptr_r] <= key_lookup(low_row, cmd.col);
    end
    if (pop_en) begin
      rd_data_r <= key_mem[rd_ptr_r];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_column_drive_n = out_drive_r;
  assign out_key_valid      = out_kv_r;
  assign out_key_code       = out_kv_r ? rd_data_r : '0;
  assign out_press_dropped  = out_drop_r;

endmodule

/* hw/rtl/keypad_scan_press_fifo.sv */
// Top level of the 4x4 keypad scanner with its key code FIFO.
//
// Usage: every input word is either a scan sample (operation 0) carrying the
// active-low row levels read while the reported column was driven low, or a
// get (operation 1) that pops one key code. Every input word gives exactly
// one output word, in order.
// Output: column_drive_n is the column to drive for the next sample; a get
// sets key_valid/key_code when a code was waiting; a scan sets press_dropped
// when a new press found the FIFO full (FIFO holds FIFO_DEPTH-1 codes).
// Path: an accepted word is written into the command queue; the back end then
// loads its result into the output register once every new press is handled.
// Throughput: one word per cycle while the output is not stalled and no scan
// word brings more than one new press; each new press takes its own FIFO write.
// Reset (synchronous, rst_n low): all keys released, column 0, FIFO empty.
// Stalls: the output register holds while out_ready is low; the front and its
// two-word command queue keep taking input until the queue fills.
module keypad_scan_press_fifo import kspf_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_operation,
  input  logic [3:0] in_row_levels_n,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] out_column_drive_n,
  output logic       out_key_valid,
  output logic [3:0] out_key_code,
  output logic       out_press_dropped
);

  cmd_t front_cmd, back_cmd;
  logic front_valid, front_ready;
  logic back_valid, back_ready;

  // classify: new presses, map and column update
  kspf_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_row_levels_n (in_row_levels_n),
    .cmd_valid       (front_valid),
    .cmd_ready       (front_ready),
    .cmd             (front_cmd)
  );

  // decouples the front from FIFO work and output stalls
  kspf_cmd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_cmd   (front_cmd),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_cmd    (back_cmd)
  );

  // pushes, pops and the output register
  kspf_back #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd_valid          (back_valid),
    .cmd_ready          (back_ready),
    .cmd                (back_cmd),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_column_drive_n (out_column_drive_n),
    .out_key_valid      (out_key_valid),
    .out_key_code       (out_key_code),
    .out_press_dropped  (out_press_dropped)
  );

endmodule

/* bench/keypad_scan_press_fifo_test.sv */
// Self-checking bench for the keypad scanner: directed table, then random scan/get traffic.
`timescale 1ns / 1ps

module keypad_scan_press_fifo_test import kspf_pkg::*; ();

  localparam int FIFO_DEPTH   = 16;
  localparam int RANDOM_WORDS = 700;
  localparam int CALM_WORDS   = 100;  // last words run with no idling at all
  localparam int HOLD_AT      = 200;  // random word that starts the long receiver hold-off
  localparam int PAUSE_AT     = 400;  // random word before which the sender drains the block
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;   // idle wait after the last expected result is checked

  // Key legend, indexed row*4 + column, same numbering as the pressed map.
  localparam logic [CODE_W-1:0] KEY_LEGEND [0:KEYS-1] = '{
    4'h1, 4'h2, 4'h3, KEY_A,
    4'h4, 4'h5, 4'h6, KEY_B,
    4'h7, 4'h8, 4'h9, KEY_C,
    4'h0, KEY_F, KEY_E, KEY_D
  };

  typedef struct packed {
    logic [COLS-1:0]   drive_n;
    logic              key_valid;
    logic [CODE_W-1:0] code;
    logic              dropped;
  } key_result_t;

  // One row of the directed table; "typed" rows carry their own answer.
  typedef struct packed {
    logic            op;
    logic [ROWS-1:0] rows_n;
    logic            typed;
    key_result_t     want;
  } table_word_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic       in_operation;
  logic [3:0] in_row_levels_n;
  logic       out_valid;
  logic       out_ready;
  logic [3:0] out_column_drive_n;
  logic       out_key_valid;
  logic [3:0] out_key_code;
  logic       out_press_dropped;

  keypad_scan_press_fifo #(.FIFO_DEPTH(FIFO_DEPTH)) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_row_levels_n   (in_row_levels_n),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_column_drive_n(out_column_drive_n),
    .out_key_valid     (out_key_valid),
    .out_key_code      (out_key_code),
    .out_press_dropped (out_press_dropped)
  );

  // Shadow copy of the scanner: held keys, scan column and the code ring.
  logic [KEYS-1:0]   held_keys;
  logic [COL_W-1:0]  scan_col;
  logic [CODE_W-1:0] code_ring [0:FIFO_DEPTH-1];
  int                ring_wr;
  int                ring_rd;

  key_result_t       pending_results [$];
  int                mismatches;

  // Traffic shaping flags shared between processes.
  logic              calm;
  int                dense_left;
  int                hold_asks;
  int                hold_served;
  int                hold_left;
  int                rx_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs or loses a word.
  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("%0t: %s got %0h want %0h", $time, what, got, want);
  endtask

  // Advance the shadow scanner by one accepted word and give its result.
  task automatic advance_keypad(input logic op, input logic [ROWS-1:0] rows_n,
                                output key_result_t res);
    int   key_idx;
    int   nxt;
    logic closed;
    res = '0;
    if (op == OP_SCAN) begin
      // Rows are handled 0..3, so a full ring drops the higher rows first.
      for (int r = 0; r < ROWS; r++) begin
        key_idx = r * COLS + scan_col;
        closed  = !rows_n[r];
        if (closed && !held_keys[key_idx]) begin
          nxt = (ring_wr + 1) % FIFO_DEPTH;
          if (nxt == ring_rd) begin
            res.dropped = 1'b1;  // ring full: press lost, key still marked held
          end else begin
            code_ring[ring_wr] = KEY_LEGEND[key_idx];
            ring_wr = nxt;
          end
        end
        held_keys[key_idx] = closed;
      end
      scan_col = scan_col + 1'b1;
    end else if (ring_rd != ring_wr) begin
      res.key_valid = 1'b1;
      res.code      = code_ring[ring_rd];
      ring_rd       = (ring_rd + 1) % FIFO_DEPTH;
    end
    res.drive_n = ~(4'b0001 << scan_col);
  endtask

  // Offer one word, hold it until taken, then queue its expected result.
  // Sometimes a short sender gap follows, outside the calm and dense stretches.
  task automatic send_word(input logic op, input logic [ROWS-1:0] rows_n,
                           input logic typed, input key_result_t typed_res);
    key_result_t res;
    @(negedge clk);
    in_valid        <= 1'b1;
    in_operation    <= op;
    in_row_levels_n <= rows_n;
    do @(posedge clk); while (!in_ready);
    advance_keypad(op, rows_n, res);
    pending_results.push_back(typed ? typed_res : res);
    if (dense_left > 0) dense_left--;
    if (!calm && dense_left == 0 && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 11)) @(negedge clk);
    end
  endtask

  // Receiver: random ready bursts, a long hold-off on request, steady in the calm tail.
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left = hold_left - 1;
      end else if (hold_served != hold_asks) begin
        hold_served = hold_asks;
        hold_left   = HOLD_CYCLES;
        out_ready  <= 1'b0;
      end else if (calm) begin
        out_ready <= 1'b1;
      end else if (rx_left > 0) begin
        rx_left = rx_left - 1;
      end else if ($urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        rx_left = $urandom_range(0, 11);
      end else begin
        out_ready <= 1'b1;
        rx_left = $urandom_range(0, 24);
      end
    end
  end

  // Result checker: every taken word against the oldest expectation.
  always @(posedge clk) begin : check_results
    key_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("word with nothing expected, drive_n", out_column_drive_n, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_column_drive_n !== want.drive_n)
          report_mismatch("column_drive_n", out_column_drive_n, want.drive_n);
        if (out_key_valid !== want.key_valid)
          report_mismatch("key_valid", out_key_valid, want.key_valid);
        if (out_key_code !== want.code)
          report_mismatch("key_code", out_key_code, want.code);
        if (out_press_dropped !== want.dropped)
          report_mismatch("press_dropped", out_press_dropped, want.dropped);
      end
    end
  end

  initial begin : stimulus
    table_word_t     directed [$];
    table_word_t     tw;
    int              get_pct;
    logic            op;
    logic [ROWS-1:0] rows_n;
    logic [KEYS-1:0] pad_keys;

    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_operation    = OP_SCAN;
    in_row_levels_n = 4'hF;
    out_ready       = 1'b0;
    calm            = 1'b0;
    dense_left      = 0;
    hold_asks       = 0;
    hold_served     = 0;
    hold_left       = 0;
    rx_left         = 0;
    mismatches      = 0;
    held_keys       = '0;
    scan_col        = '0;
    ring_wr         = 0;
    ring_rd         = 0;
    pad_keys        = '0;

    // Directed table. After reset column 0 is driven and the ring is empty.
    directed.push_back({OP_GET,  4'hF, 1'b1, 4'hE, 1'b0, 4'h0, 1'b0});  // get on empty
    directed.push_back({OP_SCAN, 4'hF, 1'b1, 4'hD, 1'b0, 4'h0, 1'b0});  // col 0, nothing
    directed.push_back({OP_SCAN, 4'h0, 1'b1, 4'hB, 1'b0, 4'h0, 1'b0});  // col 1, four presses
    directed.push_back({OP_SCAN, 4'h0, 1'b1, 4'h7, 1'b0, 4'h0, 1'b0});  // col 2, four presses
    directed.push_back({OP_SCAN, 4'h0, 1'b1, 4'hE, 1'b0, 4'h0, 1'b0});  // col 3, four presses
    // col 0: three fit, the fourth finds the ring full and is dropped
    directed.push_back({OP_SCAN, 4'h0, 1'b1, 4'hD, 1'b0, 4'h0, 1'b1});
    directed.push_back({OP_SCAN, 4'h0, 1'b0, 10'h0});                   // col 1 still held
    for (int i = 0; i < FIFO_DEPTH - 1; i++)                            // drain all codes
      directed.push_back({OP_GET, (i % 2 == 0) ? 4'h0 : 4'hF, 1'b0, 10'h0});
    directed.push_back({OP_GET,  4'h5, 1'b1, 4'hB, 1'b0, 4'h0, 1'b0});  // empty again
    directed.push_back({OP_SCAN, 4'hF, 1'b0, 10'h0});                   // col 2 released
    directed.push_back({OP_SCAN, 4'hA, 1'b0, 10'h0});                   // col 3 partial

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) begin
      tw = directed[i];
      send_word(tw.op, tw.rows_n, tw.typed, tw.want);
    end

    // Random part: mostly a simulated keypad scanned column by column, with
    // noise words mixed in and the get share changing so the ring fills and drains.
    get_pct = 35;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       get_pct = 5;
          1:       get_pct = 35;
          default: get_pct = 75;
        endcase
      end
      calm = (n >= RANDOM_WORDS - CALM_WORDS);
      if (n == HOLD_AT) begin
        // Receiver goes quiet while words keep coming, filling the command queue.
        hold_asks++;
        dense_left = 40;
      end
      if (n == PAUSE_AT) begin
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end

      if ($urandom_range(0, 99) < get_pct) begin
        op     = OP_GET;
        rows_n = ROWS'($urandom);  // row bits are don't-care on a get
      end else begin
        op = OP_SCAN;
        if ($urandom_range(0, 9) == 0) begin
          rows_n = ROWS'($urandom);  // noise: rows unrelated to the keypad
        end else begin
          if ($urandom_range(0, 3) == 0)
            pad_keys[$urandom_range(0, KEYS - 1)] ^= 1'b1;
          if ($urandom_range(0, 19) == 0)
            pad_keys = KEYS'($urandom);
          for (int r = 0; r < ROWS; r++)
            rows_n[r] = !pad_keys[r * COLS + scan_col];
        end
      end
      send_word(op, rows_n, 1'b0, '0);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
